[sv/lrupr_pkg.sv]
// Shared constants and types for the LRU page replacement core.
package lrupr_pkg;

  localparam int FRAMES    = 8;
  localparam int PAGE_BITS = 16;
  localparam int SLOT_W    = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int NUM_W     = $clog2(FRAMES + 1);
  localparam int STAMP_W   = 32;
  localparam int CNT_W     = 16;
  localparam int CFG_W     = 4;
  localparam int FSLOT_W   = 3;
  localparam int PNUM_W    = 16;
  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;

  localparam logic [CFG_W-1:0]   FRAMES_IN_USE_RESET = CFG_W'(4);
  localparam logic [STAMP_W-1:0] TIME_RESET          = STAMP_W'(1);

  typedef enum logic {
    REG_FRAMES_IN_USE = 1'b0,
    REG_UNUSED        = 1'b1
  } reg_index_t;

  typedef struct packed {
    logic                 valid;
    logic [PAGE_BITS-1:0] page;
    logic [STAMP_W-1:0]   stamp;
  } frame_rd_t;

  typedef struct packed {
    logic                 en;
    logic                 miss;
    logic [SLOT_W-1:0]    idx;
    logic [PAGE_BITS-1:0] page;
    logic [STAMP_W-1:0]   stamp;
  } frame_wr_t;

endpackage

[sv/lrupr_if.sv]
// Request and response channel interfaces for the LRU page replacement core.
interface lrupr_req_if;
  import lrupr_pkg::*;

  logic              valid;
  logic              ready;
  logic [PNUM_W-1:0] page_number;

  modport source (output valid, output page_number, input ready);
  modport sink (input valid, input page_number, output ready);
endinterface

interface lrupr_rsp_if;
  import lrupr_pkg::*;

  logic               valid;
  logic               ready;
  logic               fault;
  logic [FSLOT_W-1:0] frame_slot;
  logic [CNT_W-1:0]   fault_total;
  logic [CNT_W-1:0]   hit_total;

  modport source (output valid, output fault, output frame_slot, output fault_total,
                  output hit_total, input ready);
  modport sink (input valid, input fault, input frame_slot, input fault_total,
                input hit_total, output ready);
endinterface

[sv/lru_page_replacement_core.sv]
// Top level of the LRU page replacement core: APB register, frame table and scan sequencer.
// The scan covers the active frames (1..8, from frames_in_use) and stops at a hit; a new
// request is taken only after the previous one has left the update state.
// The scan reads one frame per cycle through a single page match and stamp compare.
// A finished response is held in an output register while the next request is taken.
// Reset: all frames empty, frames_in_use = 4, time stamp = 1, totals cleared.
module lru_page_replacement_core (
  input  logic                          clk,
  input  logic                          rst,
  lrupr_req_if.sink                     req,
  lrupr_rsp_if.source                   rsp,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lrupr_pkg::PADDR_W-1:0] paddr,
  input  logic [lrupr_pkg::PDATA_W-1:0] pwdata,
  output logic [lrupr_pkg::PDATA_W-1:0] prdata,
  output logic                          pready
);
  import lrupr_pkg::*;

  logic [CFG_W-1:0]  frames_in_use;
  reg_index_t        reg_sel;
  logic [SLOT_W-1:0] rd_idx;
  frame_rd_t         rd;
  frame_wr_t         wr;

  assign pready  = 1'b1;
  assign reg_sel = reg_index_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      frames_in_use <= FRAMES_IN_USE_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel == REG_FRAMES_IN_USE) begin
      frames_in_use <= pwdata[CFG_W-1:0];
    end
  end

  always_comb begin
    case (reg_sel)
      REG_FRAMES_IN_USE: prdata = PDATA_W'(frames_in_use);
      default:           prdata = '0;
    endcase
  end

  lrupr_frame_store u_store (
    .clk    (clk),
    .rst    (rst),
    .rd_idx (rd_idx),
    .rd     (rd),
    .wr     (wr)
  );

  lrupr_scan u_scan (
    .clk           (clk),
    .rst           (rst),
    .frames_in_use (frames_in_use),
    .req           (req),
    .rsp           (rsp),
    .rd_idx        (rd_idx),
    .rd            (rd),
    .wr            (wr)
  );

endmodule

[sv/lrupr_frame_store.sv]
// Frame table: resident pages, valid bits and last-use stamps.
module lrupr_frame_store (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [lrupr_pkg::SLOT_W-1:0] rd_idx,
  output lrupr_pkg::frame_rd_t        rd,
  input  lrupr_pkg::frame_wr_t        wr
);
  import lrupr_pkg::*;

  logic [FRAMES-1:0]    slot_valid;
  logic [PAGE_BITS-1:0] resident_page [FRAMES];
  logic [STAMP_W-1:0]   last_use [FRAMES];

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
    end else if (wr.en && wr.miss) begin
      slot_valid[wr.idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      last_use[wr.idx] <= wr.stamp;
      if (wr.miss) begin
        resident_page[wr.idx] <= wr.page;
      end
    end
  end

  always_comb begin
    rd.valid = slot_valid[rd_idx];
    rd.page  = resident_page[rd_idx];
    rd.stamp = last_use[rd_idx];
  end

  a_hit_slot_valid: assert property (@(posedge clk) disable iff (rst)
    wr.en && !wr.miss |-> slot_valid[wr.idx])
    else $error("hit update on an empty frame");

  a_fill_sets_valid: assert property (@(posedge clk) disable iff (rst)
    wr.en && wr.miss |=> slot_valid[$past(wr.idx)])
    else $error("filled frame not marked valid");

  a_valid_never_drops: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> (slot_valid & $past(slot_valid)) == $past(slot_valid))
    else $error("frame valid bit dropped");

endmodule

[sv/lrupr_scan.sv]
// Sequencer that scans frames one per cycle with a shared match and stamp compare.
module lrupr_scan (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [lrupr_pkg::CFG_W-1:0]  frames_in_use,
  lrupr_req_if.sink                    req,
  lrupr_rsp_if.source                  rsp,
  output logic [lrupr_pkg::SLOT_W-1:0] rd_idx,
  input  lrupr_pkg::frame_rd_t         rd,
  output lrupr_pkg::frame_wr_t         wr
);
  import lrupr_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE
  } state_t;

  state_t               state;
  logic [SLOT_W-1:0]    idx;
  logic [SLOT_W-1:0]    last_idx;
  logic [PAGE_BITS-1:0] page;
  logic                 hit;
  logic [SLOT_W-1:0]    hit_idx;
  logic                 best_empty;
  logic [SLOT_W-1:0]    best_idx;
  logic [STAMP_W-1:0]   best_stamp;
  logic [STAMP_W-1:0]   time_now;
  logic [CNT_W-1:0]     fault_count;
  logic [CNT_W-1:0]     hit_count;
  logic                 rsp_valid;

  logic [NUM_W-1:0]     n_active;
  logic                 match;
  logic                 older;
  logic                 out_free;
  logic [SLOT_W-1:0]    slot_sel;
  logic [CNT_W-1:0]     fault_count_next;
  logic [CNT_W-1:0]     hit_count_next;

  always_comb begin
    if (frames_in_use == '0) begin
      n_active = NUM_W'(1);
    end else if (CFG_W'(frames_in_use) > CFG_W'(FRAMES)) begin
      n_active = NUM_W'(FRAMES);
    end else begin
      n_active = NUM_W'(frames_in_use);
    end
  end

  assign match    = rd.valid && (rd.page == page);
  assign older    = (idx == '0) || (rd.stamp < best_stamp);
  assign out_free = !rsp_valid || rsp.ready;
  assign slot_sel = hit ? hit_idx : best_idx;

  always_comb begin
    fault_count_next = fault_count;
    hit_count_next   = hit_count;
    if (hit) begin
      if (hit_count != '1) begin
        hit_count_next = hit_count + CNT_W'(1);
      end
    end else if (fault_count != '1) begin
      fault_count_next = fault_count + CNT_W'(1);
    end
  end

  assign rd_idx    = idx;
  assign req.ready = (state == ST_IDLE);
  assign rsp.valid = rsp_valid;

  always_comb begin
    wr.en    = (state == ST_UPDATE) && out_free;
    wr.miss  = !hit;
    wr.idx   = slot_sel;
    wr.page  = page;
    wr.stamp = time_now;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      idx         <= '0;
      hit         <= 1'b0;
      best_empty  <= 1'b0;
      time_now    <= TIME_RESET;
      fault_count <= '0;
      hit_count   <= '0;
      rsp_valid   <= 1'b0;
    end else begin
      if (rsp_valid && rsp.ready) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (req.valid) begin
            page       <= req.page_number[PAGE_BITS-1:0];
            last_idx   <= SLOT_W'(n_active - NUM_W'(1));
            idx        <= '0;
            hit        <= 1'b0;
            best_empty <= 1'b0;
            state      <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (match) begin
            hit     <= 1'b1;
            hit_idx <= idx;
            state   <= ST_UPDATE;
          end else begin
            if (!best_empty) begin
              if (!rd.valid) begin
                best_empty <= 1'b1;
                best_idx   <= idx;
              end else if (older) begin
                best_idx   <= idx;
                best_stamp <= rd.stamp;
              end
            end
            if (idx == last_idx) begin
              state <= ST_UPDATE;
            end else begin
              idx <= idx + SLOT_W'(1);
            end
          end
        end
        ST_UPDATE: begin
          if (out_free) begin
            fault_count     <= fault_count_next;
            hit_count       <= hit_count_next;
            time_now        <= time_now + STAMP_W'(1);
            rsp_valid       <= 1'b1;
            rsp.fault       <= !hit;
            rsp.frame_slot  <= FSLOT_W'(slot_sel);
            rsp.fault_total <= fault_count_next;
            rsp.hit_total   <= hit_count_next;
            state           <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_accept_starts_scan: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> state == ST_SCAN && idx == '0)
    else $error("accepted transaction did not start a scan");

  a_time_advances: assert property (@(posedge clk) disable iff (rst)
    wr.en |=> time_now == $past(time_now) + STAMP_W'(1))
    else $error("time stamp did not advance on update");

  a_faults_monotonic: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> fault_count >= $past(fault_count) && hit_count >= $past(hit_count))
    else $error("totals decreased");

  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_SCAN |-> idx <= last_idx)
    else $error("scan index beyond active frames");

endmodule
